>>> src/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled edge outside reset
`define VPM_ASSERT_HOLD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define VPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/vpm_pkg.sv
`timescale 1ns / 1ps

package vpm_pkg;

    localparam int TIME_W   = 48;
    localparam int COUNT_W  = 40;
    localparam int FRAMES_W = 32;
    localparam int VBL_W    = 34;
    localparam int AVG_W    = 56;
    localparam int SUM_W    = 60;
    localparam int IDLE_W   = 8;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic [IDLE_W-1:0] IDLE_RESET = 8'd4;

    // register index codes
    localparam logic REG_GAP_LIMIT = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SUM,
        ST_AVG,
        ST_COUNT,
        ST_POST
    } state_t;

endpackage

>>> src/vpm_if.sv
`timescale 1ns / 1ps

interface vpm_in_if;
    import vpm_pkg::*;

    logic                valid;
    logic                ready;
    logic                reading_valid;
    logic [TIME_W-1:0]   time_us;
    logic [COUNT_W-1:0]  vblank_count;

    modport source (output valid, output reading_valid, output time_us,
                    output vblank_count, input ready);
    modport sink   (input valid, input reading_valid, input time_us,
                    input vblank_count, output ready);
endinterface

interface vpm_out_if;
    import vpm_pkg::*;

    logic                valid;
    logic                ready;
    logic                has_reading;
    logic [COUNT_W-1:0]  last_vblank;
    logic [FRAMES_W-1:0] frame_total;
    logic [VBL_W-1:0]    vblank_total;
    logic [AVG_W-1:0]    period_avg;

    modport source (output valid, output has_reading, output last_vblank,
                    output frame_total, output vblank_total, output period_avg,
                    input ready);
    modport sink   (input valid, input has_reading, input last_vblank,
                    input frame_total, input vblank_total, input period_avg,
                    output ready);
endinterface

>>> src/vpm_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module vpm_div #(
    parameter int NW = 56,
    parameter int DW = 40
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [DW-1:0] den_reg, den_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [CW-1:0] count_reg, count_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    always_comb
    begin
        trial      = {rem_reg, num_reg[NW-1]};
        diff       = trial - {1'b0, den_reg};
        ge         = (trial >= {1'b0, den_reg});
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            num_next   = num;
            den_next   = den;
            rem_next   = '0;
            count_next = CW'(NW);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            // quotient bits enter from the bottom as dividend bits leave the top
            num_next   = {num_reg[NW-2:0], ge};
            rem_next   = ge ? diff[DW-1:0] : trial[DW-1:0];
            count_next = count_reg - 1'b1;
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

>>> src/vpm_div10.sv
`timescale 1ns / 1ps

// divide by ten, one hex digit per cycle, remainder kept below ten
module vpm_div10 #(
    parameter int W = 60
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] num,
    output logic         done,
    output logic [W-1:0] quo
);
    localparam int DIGITS = W / 4;
    localparam int CW     = $clog2(DIGITS + 1);

    logic [W-1:0]  num_reg, num_next;
    logic [3:0]    rem_reg, rem_next;
    logic [CW-1:0] count_reg, count_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [7:0]    step;

    // partial value below 160: four trial subtracts of 80, 40, 20, 10
    function automatic logic [7:0] div10_step(input logic [7:0] p);
        logic [7:0] r;
        logic [3:0] q;
        r = p;
        q = '0;
        for (int i = 3; i >= 0; i--)
        begin
            if (r >= (8'd10 << i))
            begin
                r    = r - (8'd10 << i);
                q[i] = 1'b1;
            end
        end
        return {q, r[3:0]};
    endfunction

    always_comb
    begin
        step       = div10_step({rem_reg, num_reg[W-1 -: 4]});
        num_next   = num_reg;
        rem_next   = rem_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            num_next   = num;
            rem_next   = '0;
            count_next = CW'(DIGITS);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next   = {num_reg[W-5:0], step[7:4]};
            rem_next   = step[3:0];
            count_next = count_reg - 1'b1;
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign quo  = num_reg;

endmodule

>>> src/vpm_apb.sv
`timescale 1ns / 1ps

module vpm_apb (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vpm_pkg::ADDR_W-1:0] paddr,
    input  logic [vpm_pkg::DATA_W-1:0] pwdata,
    output logic [vpm_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output logic [vpm_pkg::IDLE_W-1:0] gap_limit
);
    import vpm_pkg::*;

    logic [IDLE_W-1:0] idle_reg, idle_next;
    logic              reg_index;

    assign reg_index = paddr[ADDR_W-1];

    always_comb
    begin
        idle_next = idle_reg;
        if (psel && penable && pwrite && (reg_index == REG_GAP_LIMIT))
        begin
            idle_next = pwdata[IDLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_reg <= IDLE_RESET;
        end
        else
        begin
            idle_reg <= idle_next;
        end
    end

    assign prdata    = (reg_index == REG_GAP_LIMIT) ? DATA_W'(idle_reg) : '0;
    assign pready    = 1'b1;
    assign gap_limit = idle_reg;

endmodule

>>> src/vblank_pacing_monitor_unit.sv
`timescale 1ns / 1ps

// channel   modport  fields
// reading   sink     reading_valid, time_us, vblank_count
// result    source   has_reading, last_vblank, frame_total, vblank_total, period_avg
// apb       slave    gap_limit at byte address 0
//
// one item at a time; a reading that measures nothing goes from idle straight to post,
// one that only counts passes the count state first; a reading with a period first runs
// the bit-serial divider (48 + PERIOD_FRAC_BITS % 16 steps) and, when it folds into the
// average rather than seeding it, then the 15-digit divide by ten
// reset clears the pacing state and the output valid; gap_limit resets to 4
// a stalled result holds in the output register while the next item is taken
module vblank_pacing_monitor_unit #(
    parameter int PERIOD_FRAC_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    vpm_in_if.sink                     reading,
    vpm_out_if.source                  result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vpm_pkg::ADDR_W-1:0] paddr,
    input  logic [vpm_pkg::DATA_W-1:0] pwdata,
    output logic [vpm_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import vpm_pkg::*;

    // shift amount wraps at 16
    localparam int SHIFT = PERIOD_FRAC_BITS % 16;
    localparam int NUM_W = TIME_W + SHIFT;
    localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(5);

    state_t state_reg, state_next;

    logic                seen_reg, seen_next;
    logic [COUNT_W-1:0]  prev_count_reg, prev_count_next;
    logic [TIME_W-1:0]   prev_time_reg, prev_time_next;
    logic [FRAMES_W-1:0] frames_reg, frames_next;
    logic [VBL_W-1:0]    vblanks_reg, vblanks_next;
    logic [AVG_W-1:0]    avg_reg, avg_next;
    logic [COUNT_W-1:0]  steps_reg, steps_next;
    logic [AVG_W-1:0]    q_reg, q_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_seen_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    logic [FRAMES_W-1:0] out_frames_reg;
    logic [VBL_W-1:0]    out_vblanks_reg;
    logic [AVG_W-1:0]    out_avg_reg;
    logic                out_load;

    logic [IDLE_W-1:0]   gap_limit;
    logic                advance;
    logic                time_adv;
    logic [COUNT_W-1:0]  steps;
    logic [TIME_W-1:0]   delta;
    logic                div_start;
    logic                div_done;
    logic [NUM_W-1:0]    div_quo;
    logic [63:0]         q_ext;
    logic [AVG_W-1:0]    q_sat;
    logic                sum_start;
    logic [SUM_W-1:0]    sum;
    logic                div10_done;
    logic [SUM_W-1:0]    div10_quo;
    logic [VBL_W:0]      vbl_sum;

    vpm_apb u_apb (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .gap_limit (gap_limit)
    );

    vpm_div #(
        .NW (NUM_W),
        .DW (COUNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (NUM_W'(delta) << SHIFT),
        .den   (steps),
        .done  (div_done),
        .quo   (div_quo)
    );

    vpm_div10 #(
        .W (SUM_W)
    ) u_div10 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sum_start),
        .num   (sum),
        .done  (div10_done),
        .quo   (div10_quo)
    );

    assign advance  = seen_reg && (reading.vblank_count > prev_count_reg);
    assign time_adv = reading.time_us > prev_time_reg;
    assign steps    = reading.vblank_count - prev_count_reg;
    assign delta    = reading.time_us - prev_time_reg;

    // quotient clamps to the average width
    assign q_ext = 64'(div_quo);
    assign q_sat = (|q_ext[63:AVG_W]) ? '1 : q_ext[AVG_W-1:0];

    // 9*avg + new + 5, then divided by ten
    assign sum = (SUM_W'(avg_reg) << 3) + SUM_W'(avg_reg) + SUM_W'(q_reg) + ROUND_BIAS;

    assign vbl_sum = (VBL_W + 1)'(vblanks_reg) + (VBL_W + 1)'(steps_reg[IDLE_W-1:0]);

    assign reading.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        seen_next       = seen_reg;
        prev_count_next = prev_count_reg;
        prev_time_next  = prev_time_reg;
        frames_next     = frames_reg;
        vblanks_next    = vblanks_reg;
        avg_next        = avg_reg;
        steps_next      = steps_reg;
        q_next          = q_reg;
        div_start       = 1'b0;
        sum_start       = 1'b0;
        out_load        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (reading.valid)
                begin
                    if (reading.reading_valid)
                    begin
                        seen_next       = 1'b1;
                        prev_count_next = reading.vblank_count;
                        prev_time_next  = reading.time_us;
                        steps_next      = steps;
                        if (advance && time_adv)
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        else if (advance)
                        begin
                            state_next = ST_COUNT;
                        end
                        else
                        begin
                            state_next = ST_POST;
                        end
                    end
                    else
                    begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    q_next = q_sat;
                    if (q_sat == '0)
                    begin
                        state_next = ST_COUNT;
                    end
                    else if (avg_reg == '0)
                    begin
                        // unknown average seeds from the first period
                        avg_next   = q_sat;
                        state_next = ST_COUNT;
                    end
                    else
                    begin
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM:
            begin
                sum_start  = 1'b1;
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                if (div10_done)
                begin
                    avg_next   = div10_quo[AVG_W-1:0];
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                if (steps_reg <= COUNT_W'(gap_limit))
                begin
                    if (frames_reg != '1)
                    begin
                        frames_next = frames_reg + 1'b1;
                    end
                    vblanks_next = vbl_sum[VBL_W] ? '1 : vbl_sum[VBL_W-1:0];
                end
                state_next = ST_POST;
            end
            ST_POST:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            seen_reg       <= 1'b0;
            prev_count_reg <= '0;
            prev_time_reg  <= '0;
            frames_reg     <= '0;
            vblanks_reg    <= '0;
            avg_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seen_reg       <= seen_next;
            prev_count_reg <= prev_count_next;
            prev_time_reg  <= prev_time_next;
            frames_reg     <= frames_next;
            vblanks_reg    <= vblanks_next;
            avg_reg        <= avg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steps_reg <= steps_next;
        q_reg     <= q_next;
        if (out_load)
        begin
            out_seen_reg    <= seen_reg;
            out_count_reg   <= prev_count_reg;
            out_frames_reg  <= frames_reg;
            out_vblanks_reg <= vblanks_reg;
            out_avg_reg     <= avg_reg;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.has_reading  = out_seen_reg;
    assign result.last_vblank  = out_count_reg;
    assign result.frame_total  = out_frames_reg;
    assign result.vblank_total = out_vblanks_reg;
    assign result.period_avg   = out_avg_reg;

endmodule

>>> src/vpm_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vpm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic                         has_reading,
    input logic [vpm_pkg::COUNT_W-1:0]  last_vblank,
    input logic [vpm_pkg::FRAMES_W-1:0] frame_total,
    input logic [vpm_pkg::VBL_W-1:0]    vblank_total,
    input logic [vpm_pkg::AVG_W-1:0]    period_avg
);
    import vpm_pkg::*;

    // a waiting result keeps its average, frame total and last vblank
    `VPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(period_avg) && $stable(frame_total) && $stable(last_vblank), "result changed while stalled")

    // nothing is measured or counted before the first valid reading
    `VPM_ASSERT_HOLD(a_no_reading, clk, rst_n, (out_valid && !has_reading) |-> (last_vblank == '0 && frame_total == '0 && vblank_total == '0 && period_avg == '0), "state set before any reading")

    // every counted frame spans at least one vblank
    `VPM_ASSERT_HOLD(a_totals, clk, rst_n, out_valid |-> (VBL_W'(frame_total) <= vblank_total), "frame total above vblank total")

    // one item in flight: no accept on the cycle after an accept
    `VPM_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "item taken while busy")

endmodule

bind vblank_pacing_monitor_unit vpm_checker u_vpm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (reading.valid),
    .in_ready     (reading.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .has_reading  (result.has_reading),
    .last_vblank  (result.last_vblank),
    .frame_total  (result.frame_total),
    .vblank_total (result.vblank_total),
    .period_avg   (result.period_avg)
);
